[rtl/cht_pkg.sv]
// Shared types, constants and width helpers for the chained hash table.
// No dependencies; every other file in rtl/ refers to it by scoped names.
package cht_pkg;

    localparam int BUCKETS_DEF    = 8;
    localparam int POOL_NODES_DEF = 64;
    localparam int VALUE_BITS_DEF = 64;

    localparam int KEY_W        = 31;
    localparam int STATUS_W     = 3;
    localparam int BUCKET_OUT_W = 3;
    localparam int VALUE_OUT_W  = 64;
    localparam int IN_TDATA_W   = 96;
    localparam int OUT_TDATA_W  = 72;
    localparam int QUEUE_DEPTH  = 2;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_UPDATED   = 3'd1,
        ST_FOUND     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_POOL_FULL = 3'd4
    } t_status;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_SEARCH = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } t_front_state;

    typedef enum logic [1:0] {
        B_IDLE,
        B_HEAD,
        B_WALK,
        B_DONE
    } t_back_state;

    function automatic int bkt_w(input int buckets);
        return (buckets > 1) ? $clog2(buckets) : 1;
    endfunction

    // Width of one queued item: bucket, opcode, key and value.
    function automatic int item_w(input int buckets, input int value_bits);
        return bkt_w(buckets) + 1 + KEY_W + value_bits;
    endfunction

endpackage

[rtl/cht_front.sv]
// Front end of the chained hash table: accepts transactions and works out the bucket.
// Depends on cht_pkg.
module cht_front #(
    parameter int BUCKETS    = cht_pkg::BUCKETS_DEF,
    parameter int VALUE_BITS = cht_pkg::VALUE_BITS_DEF
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_s_tvalid,
    output logic                                            o_s_tready,
    input  logic [cht_pkg::IN_TDATA_W-1:0]                  i_s_tdata,
    input  logic                                            i_s_tuser,
    output logic                                            o_push_valid,
    input  logic                                            i_push_ready,
    output logic [cht_pkg::item_w(BUCKETS, VALUE_BITS)-1:0] o_push_data
);

    localparam int BKT_W  = cht_pkg::bkt_w(BUCKETS);
    localparam int RCP_W  = cht_pkg::KEY_W + 1;
    localparam int PROD_W = cht_pkg::KEY_W + RCP_W;
    localparam int RCP_SH = cht_pkg::KEY_W + $clog2(BUCKETS);
    // Rounded-up reciprocal of BUCKETS; at this scale the product gives the exact
    // quotient of every key.
    localparam longint unsigned RCP_M =
        ((64'd1 << RCP_SH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
    localparam logic [RCP_W-1:0] RCP_C  = RCP_W'(RCP_M);
    localparam logic [BKT_W-1:0] BKT_LO = BKT_W'(BUCKETS);

    cht_pkg::t_front_state r_state, n_state;

    logic                        r_op;
    logic [cht_pkg::KEY_W-1:0]   r_key;
    logic [VALUE_BITS-1:0]       r_val;
    logic [PROD_W-1:0]           r_prod;
    logic [BKT_W-1:0]            w_quo_lo;
    logic [BKT_W-1:0]            w_rem;
    logic                        w_accept;

    assign w_accept = i_s_tvalid && o_s_tready;

    // The remainder is below BUCKETS, so the low bits of the key and of the
    // quotient are enough to form it.
    assign w_quo_lo = r_prod[RCP_SH +: BKT_W];
    assign w_rem    = r_key[BKT_W-1:0] - w_quo_lo * BKT_LO;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cht_pkg::F_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = cht_pkg::F_DIV;
                end
            end
            cht_pkg::F_DIV: begin
                n_state = cht_pkg::F_PUSH;
            end
            cht_pkg::F_PUSH: begin
                if (i_push_ready) begin
                    n_state = i_s_tvalid ? cht_pkg::F_DIV : cht_pkg::F_IDLE;
                end
            end
            default: n_state = cht_pkg::F_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready   = 1'b0;
        o_push_valid = 1'b0;
        unique case (r_state)
            cht_pkg::F_IDLE: o_s_tready = 1'b1;
            cht_pkg::F_DIV:  o_s_tready = 1'b0;
            cht_pkg::F_PUSH: begin
                o_push_valid = 1'b1;
                o_s_tready   = i_push_ready;
            end
            default: o_s_tready = 1'b0;
        endcase
    end

    assign o_push_data = {w_rem, r_op, r_key, r_val};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cht_pkg::F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= i_s_tuser;
            r_key <= i_s_tdata[cht_pkg::KEY_W-1:0];
            r_val <= VALUE_BITS'(i_s_tdata[cht_pkg::KEY_W +: cht_pkg::VALUE_OUT_W]);
        end
        if (r_state == cht_pkg::F_DIV) begin
            r_prod <= PROD_W'(r_key) * PROD_W'(RCP_C);
        end
    end

`ifndef NO_ASSERTIONS
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cht_pkg::F_PUSH) |-> ({1'b0, w_rem} < (BKT_W + 1)'(BUCKETS)))
        else $error("bucket remainder out of range");
`endif

endmodule

[rtl/cht_fifo.sv]
// Short queue between the front end and the chain walker of the hash table.
// Depends on cht_pkg for its default depth.
module cht_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = cht_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output logic [WIDTH-1:0] o_pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push, w_pop;

    assign o_push_ready = (r_count != CNT_FULL);
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= (r_wptr == PTR_LAST) ? '0 : r_wptr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == PTR_LAST) ? '0 : r_rptr + PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

endmodule

[rtl/cht_back.sv]
// Back end of the chained hash table: walks bucket chains in node memory,
// inserts or updates nodes and holds the result in an output register.
// Depends on cht_pkg.
module cht_back #(
    parameter int BUCKETS    = cht_pkg::BUCKETS_DEF,
    parameter int POOL_NODES = cht_pkg::POOL_NODES_DEF,
    parameter int VALUE_BITS = cht_pkg::VALUE_BITS_DEF
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_pop_valid,
    output logic                                            o_pop_ready,
    input  logic [cht_pkg::item_w(BUCKETS, VALUE_BITS)-1:0] i_pop_data,
    output logic                                            o_m_tvalid,
    input  logic                                            i_m_tready,
    output logic [cht_pkg::OUT_TDATA_W-1:0]                 o_m_tdata,
    output logic [cht_pkg::STATUS_W-1:0]                    o_m_tuser
);

    localparam int BKT_W  = cht_pkg::bkt_w(BUCKETS);
    localparam int ADDR_W = $clog2(POOL_NODES);
    localparam int IDX_W  = $clog2(POOL_NODES + 1);
    localparam int KL_W   = cht_pkg::KEY_W + IDX_W;
    localparam logic [IDX_W-1:0] NIL = IDX_W'(POOL_NODES);

    cht_pkg::t_back_state r_state, n_state;

    // Payload of the item in progress.
    logic                       r_op;
    logic [cht_pkg::KEY_W-1:0]  r_key;
    logic [VALUE_BITS-1:0]      r_val;
    logic [BKT_W-1:0]           r_bkt;

    logic [IDX_W-1:0]           r_idx;
    logic                       r_hit;
    logic [IDX_W-1:0]           r_used;

    // Bucket heads: one memory word per bucket, valid bits cleared at reset.
    logic [IDX_W-1:0]           r_head_mem [BUCKETS];
    logic [BUCKETS-1:0]         r_head_vld;
    logic [IDX_W-1:0]           r_head_q;
    logic                       r_head_v;

    // Node pool: key and link share one word, the value has its own memory.
    logic [KL_W-1:0]            r_kl_mem  [POOL_NODES];
    logic [VALUE_BITS-1:0]      r_val_mem [POOL_NODES];
    logic [KL_W-1:0]            r_kl_q;
    logic [VALUE_BITS-1:0]      r_v_q;

    logic                       r_out_valid;
    cht_pkg::t_status           r_out_status;
    logic [cht_pkg::BUCKET_OUT_W-1:0] r_out_bucket;
    logic [cht_pkg::VALUE_OUT_W-1:0]  r_out_value;

    logic                       w_op;
    logic [cht_pkg::KEY_W-1:0]  w_key;
    logic [VALUE_BITS-1:0]      w_val;
    logic [BKT_W-1:0]           w_bkt;
    logic                       w_pop;
    logic [IDX_W-1:0]           w_head;
    logic [IDX_W-1:0]           w_link_q;
    logic [cht_pkg::KEY_W-1:0]  w_key_q;
    logic [IDX_W-1:0]           w_cand;
    logic                       w_cand_ok;
    logic                       w_key_hit;
    logic                       w_out_free;
    logic                       w_full;
    logic                       w_node_rd;
    logic [ADDR_W-1:0]          w_node_addr;
    logic                       w_done;
    logic                       w_ins;
    logic                       w_upd;
    logic [ADDR_W-1:0]          w_val_addr;
    cht_pkg::t_status           w_status;
    logic [cht_pkg::VALUE_OUT_W-1:0] w_found;

    assign w_val = i_pop_data[VALUE_BITS-1:0];
    assign w_key = i_pop_data[VALUE_BITS +: cht_pkg::KEY_W];
    assign w_op  = i_pop_data[VALUE_BITS + cht_pkg::KEY_W];
    assign w_bkt = i_pop_data[VALUE_BITS + cht_pkg::KEY_W + 1 +: BKT_W];

    assign w_head     = r_head_v ? r_head_q : NIL;
    assign w_key_q    = r_kl_q[cht_pkg::KEY_W-1:0];
    assign w_link_q   = r_kl_q[cht_pkg::KEY_W +: IDX_W];
    // The next node to visit comes from the bucket head first, then from links.
    assign w_cand     = (r_state == cht_pkg::B_HEAD) ? w_head : w_link_q;
    assign w_cand_ok  = (w_cand < r_used);
    assign w_key_hit  = (w_key_q == r_key);
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_full     = (r_used == NIL);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cht_pkg::B_IDLE: begin
                if (i_pop_valid) begin
                    n_state = cht_pkg::B_HEAD;
                end
            end
            cht_pkg::B_HEAD: begin
                n_state = w_cand_ok ? cht_pkg::B_WALK : cht_pkg::B_DONE;
            end
            cht_pkg::B_WALK: begin
                if (w_key_hit || !w_cand_ok) begin
                    n_state = cht_pkg::B_DONE;
                end
            end
            cht_pkg::B_DONE: begin
                if (w_out_free) begin
                    n_state = cht_pkg::B_IDLE;
                end
            end
            default: n_state = cht_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        o_pop_ready = 1'b0;
        w_node_rd   = 1'b0;
        w_done      = 1'b0;
        unique case (r_state)
            cht_pkg::B_IDLE: o_pop_ready = 1'b1;
            cht_pkg::B_HEAD: w_node_rd   = w_cand_ok;
            cht_pkg::B_WALK: w_node_rd   = !w_key_hit && w_cand_ok;
            cht_pkg::B_DONE: w_done      = w_out_free;
            default:         o_pop_ready = 1'b0;
        endcase
    end

    assign w_pop       = i_pop_valid && o_pop_ready;
    assign w_node_addr = w_cand[ADDR_W-1:0];
    assign w_ins       = w_done && (r_op == cht_pkg::OP_INSERT) && !r_hit && !w_full;
    assign w_upd       = w_done && (r_op == cht_pkg::OP_INSERT) && r_hit;
    assign w_val_addr  = r_hit ? r_idx[ADDR_W-1:0] : r_used[ADDR_W-1:0];

    always_comb begin
        w_found = '0;
        if (r_op == cht_pkg::OP_SEARCH) begin
            if (r_hit) begin
                w_status = cht_pkg::ST_FOUND;
                w_found  = cht_pkg::VALUE_OUT_W'(r_v_q);
            end else begin
                w_status = cht_pkg::ST_NOT_FOUND;
            end
        end else if (r_hit) begin
            w_status = cht_pkg::ST_UPDATED;
        end else if (w_full) begin
            w_status = cht_pkg::ST_POOL_FULL;
        end else begin
            w_status = cht_pkg::ST_INSERTED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cht_pkg::B_IDLE;
            r_used      <= '0;
            r_head_vld  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_ins) begin
                r_used            <= r_used + IDX_W'(1);
                r_head_vld[r_bkt] <= 1'b1;
            end
            if (w_done) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_op     <= w_op;
            r_key    <= w_key;
            r_val    <= w_val;
            r_bkt    <= w_bkt;
            r_head_q <= r_head_mem[w_bkt];
            r_head_v <= r_head_vld[w_bkt];
        end
        if (r_state == cht_pkg::B_HEAD) begin
            r_hit <= 1'b0;
        end else if (r_state == cht_pkg::B_WALK && w_key_hit) begin
            r_hit <= 1'b1;
        end
        if (w_node_rd) begin
            r_idx <= w_cand;
        end
        if (w_done) begin
            r_out_status <= w_status;
            r_out_bucket <= cht_pkg::BUCKET_OUT_W'(r_bkt);
            r_out_value  <= w_found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ins) begin
            r_head_mem[r_bkt] <= r_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ins) begin
            r_kl_mem[r_used[ADDR_W-1:0]] <= {w_head, r_key};
        end
        if (w_node_rd) begin
            r_kl_q <= r_kl_mem[w_node_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ins || w_upd) begin
            r_val_mem[w_val_addr] <= r_val;
        end
        if (w_node_rd) begin
            r_v_q <= r_val_mem[w_node_addr];
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_status;
    assign o_m_tdata  = cht_pkg::OUT_TDATA_W'({r_out_value, r_out_bucket});

`ifndef NO_ASSERTIONS
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= NIL)
        else $error("node pool count beyond pool size");

    a_walk_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cht_pkg::B_WALK) |-> (r_idx < r_used))
        else $error("chain walk reached an unallocated node");

    a_used_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_used)) |->
            ((r_used == $past(r_used) + 1) && r_out_valid &&
             (r_out_status == cht_pkg::ST_INSERTED)))
        else $error("node allocated without an inserted result");
`endif

endmodule

[rtl/chained_hash_table_top.sv]
// Top level of the chained hash table: front end, queue and chain walker.
// Depends on cht_pkg, cht_front, cht_fifo and cht_back.
//
//  channel  direction  handshake               tuser        tdata (low bit up)
//  s        in         i_s_tvalid/o_s_tready   opcode [0]   key [30:0], value [94:31]
//  m        out        o_m_tvalid/i_m_tready   status [2:0] bucket [2:0], found_value [66:3]
//
// The front end steps through the accept, the reciprocal product that yields the bucket,
// and the push, which overlaps the next accept when the queue takes the item; it takes
// no new transaction while the product is being formed.
// The chain walker reads the bucket head, then visits the chain nodes one by one through
// the registered read of node memory that each link follows, one item at a time.
// Reset is synchronous and clears control state and the bucket valid bits; no clearing
// pass is run. A two-entry queue and the output register buffer the two sides; a stall
// on the output side holds up the input once the queue is full.
module chained_hash_table_top #(
    parameter int BUCKETS    = cht_pkg::BUCKETS_DEF,
    parameter int POOL_NODES = cht_pkg::POOL_NODES_DEF,
    parameter int VALUE_BITS = cht_pkg::VALUE_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [cht_pkg::IN_TDATA_W-1:0]   i_s_tdata,   // key, value
    input  logic                             i_s_tuser,   // opcode
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [cht_pkg::OUT_TDATA_W-1:0]  o_m_tdata,   // bucket, found_value
    output logic [cht_pkg::STATUS_W-1:0]     o_m_tuser    // status
);

    localparam int ITEM_W = cht_pkg::item_w(BUCKETS, VALUE_BITS);

    logic              w_push_valid, w_push_ready;
    logic [ITEM_W-1:0] w_push_data;
    logic              w_pop_valid, w_pop_ready;
    logic [ITEM_W-1:0] w_pop_data;

    cht_front #(
        .BUCKETS    (BUCKETS),
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .o_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_push_data  (w_push_data)
    );

    cht_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (cht_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_data  (w_push_data),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_data   (w_pop_data)
    );

    cht_back #(
        .BUCKETS    (BUCKETS),
        .POOL_NODES (POOL_NODES),
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (w_pop_valid),
        .o_pop_ready (w_pop_ready),
        .i_pop_data  (w_pop_data),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

endmodule

[dv/tb.sv]
// Self-checking testbench for chained_hash_table_top: inserts and searches go in on
// the slave stream and every result is checked against an in-bench hash table model.
// Depends on rtl/cht_pkg.sv and rtl/chained_hash_table_top.sv.
`timescale 1ns / 1ps

module tb;

    localparam int NUM_BUCKETS = 8;
    localparam int NUM_NODES   = 64;
    localparam int PHASE_ITEMS = 108;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 120;

    typedef struct {
        cht_pkg::t_opcode        opcode;
        bit [cht_pkg::KEY_W-1:0] key;
        bit [63:0]               value;
    } t_table_op;

    typedef struct {
        cht_pkg::t_status status;
        bit [2:0]         bucket;
        bit [63:0]        value;
    } t_table_result;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_s_tvalid = 1'b0;
    logic                            o_s_tready;
    logic [cht_pkg::IN_TDATA_W-1:0]  i_s_tdata = '0;  // key [30:0], value [94:31]
    logic                            i_s_tuser = 1'b0;  // opcode
    logic                            o_m_tvalid;
    logic                            i_m_tready = 1'b0;
    logic [cht_pkg::OUT_TDATA_W-1:0] o_m_tdata;  // bucket [2:0], found_value [66:3]
    logic [cht_pkg::STATUS_W-1:0]    o_m_tuser;  // status

    chained_hash_table_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // Model of the table contents; a null link is the index NUM_NODES.
    bit [6:0]                chain_head [NUM_BUCKETS];
    bit [cht_pkg::KEY_W-1:0] node_key   [NUM_NODES];
    bit [63:0]               node_value [NUM_NODES];
    bit [6:0]                node_next  [NUM_NODES];
    int                      nodes_taken = 0;

    t_table_op               pending_ops[$];
    t_table_result           expected_results[$];
    bit [cht_pkg::KEY_W-1:0] used_keys[$];
    t_table_op               cur_op;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_go = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;
    int errors = 0;
    int ops_accepted = 0;
    int results_seen = 0;
    int status_count [5];

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("Timeout after %0d transactions accepted, %0d results", ops_accepted,
                 results_seen);
        $display("Verification failed");
        $finish;
    end

    task automatic report_mismatch(input string what);
        errors++;
        $display("[%0t] MISMATCH: %s", $realtime, what);
    endtask

    // Applies one operation to the model table and returns the result it must produce.
    function automatic t_table_result hash_table_apply(input t_table_op op);
        t_table_result res;
        bit [2:0] b;
        int idx;
        int hit;
        b = 3'(op.key % NUM_BUCKETS);
        hit = NUM_NODES;
        idx = chain_head[b];
        for (int steps = 0; steps < NUM_NODES; steps++) begin
            if (idx >= nodes_taken || idx >= NUM_NODES) break;
            if (node_key[idx] == op.key) begin
                hit = idx;
                break;
            end
            idx = node_next[idx];
        end
        res.bucket = b;
        res.value = '0;
        if (op.opcode == cht_pkg::OP_SEARCH) begin
            if (hit != NUM_NODES) begin
                res.status = cht_pkg::ST_FOUND;
                res.value = node_value[hit];
            end else begin
                res.status = cht_pkg::ST_NOT_FOUND;
            end
        end else if (hit != NUM_NODES) begin
            node_value[hit] = op.value;
            res.status = cht_pkg::ST_UPDATED;
        end else if (nodes_taken >= NUM_NODES) begin
            res.status = cht_pkg::ST_POOL_FULL;
        end else begin
            node_key[nodes_taken] = op.key;
            node_value[nodes_taken] = op.value;
            node_next[nodes_taken] = chain_head[b];
            chain_head[b] = 7'(nodes_taken);
            nodes_taken++;
            res.status = cht_pkg::ST_INSERTED;
        end
        return res;
    endfunction

    task automatic queue_op(input cht_pkg::t_opcode opcode,
                            input bit [cht_pkg::KEY_W-1:0] key,
                            input bit [63:0] value);
        t_table_op op;
        op.opcode = opcode;
        op.key = key;
        op.value = value;
        pending_ops.push_back(op);
        used_keys.push_back(key);
    endtask

    // Mostly keys seen before, so that updates and hits are common; the rest are fresh.
    task automatic queue_random_op();
        bit [cht_pkg::KEY_W-1:0] key;
        bit [63:0] value;
        cht_pkg::t_opcode opcode;
        if (used_keys.size() != 0 && $urandom_range(99) < 55) begin
            key = used_keys[$urandom_range(used_keys.size() - 1)];
        end else begin
            case ($urandom_range(9))
                0: key = cht_pkg::KEY_W'($urandom_range(15));
                1: key = cht_pkg::KEY_W'({cht_pkg::KEY_W{1'b1}} - $urandom_range(15));
                default: key = cht_pkg::KEY_W'($urandom);
            endcase
        end
        case ($urandom_range(7))
            0: value = '0;
            1: value = '1;
            default: value = {$urandom, $urandom};
        endcase
        opcode = $urandom_range(1) ? cht_pkg::OP_SEARCH : cht_pkg::OP_INSERT;
        queue_op(opcode, key, value);
    endtask

    task automatic wait_for_drain();
        while (pending_ops.size() != 0 || i_s_tvalid) @(negedge i_clk);
        while (expected_results.size() != 0) @(negedge i_clk);
    endtask

    // Sender: keeps a transaction on the bus until it is taken, then predicts it.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                expected_results.push_back(hash_table_apply(cur_op));
                ops_accepted++;
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_op = pending_ops.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata <= {1'b0, cur_op.value, cur_op.key};
                    i_s_tuser <= cur_op.opcode;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, started once on request from the stimulus.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_go && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Receiver: checks every result transaction against the oldest expectation.
    always @(posedge i_clk) begin
        t_table_result want;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                results_seen++;
                if (o_m_tuser < 5) status_count[o_m_tuser]++;
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result status %0d with nothing expected",
                                              o_m_tuser));
                end else begin
                    want = expected_results.pop_front();
                    if (o_m_tuser !== want.status)
                        report_mismatch($sformatf("status %0d, expected %s", o_m_tuser,
                                                  want.status.name()));
                    if (o_m_tdata[2:0] !== want.bucket)
                        report_mismatch($sformatf("bucket %0d, expected %0d",
                                                  o_m_tdata[2:0], want.bucket));
                    if (o_m_tdata[66:3] !== want.value)
                        report_mismatch($sformatf("found_value %h, expected %h",
                                                  o_m_tdata[66:3], want.value));
                end
            end
            i_m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        int send_pct [4];
        int recv_pct [4];
        send_pct = '{0, 82, 0, 22};
        recv_pct = '{0, 0, 82, 22};
        for (int i = 0; i < NUM_BUCKETS; i++) chain_head[i] = NUM_NODES;
        for (int i = 0; i < 5; i++) status_count[i] = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty buckets, key and value extremes, a four-deep chain in
        // bucket zero, hits at head, middle and tail, and an in-place update.
        queue_op(cht_pkg::OP_SEARCH, 31'd3, 64'd0);
        queue_op(cht_pkg::OP_INSERT, 31'd0, 64'd0);
        queue_op(cht_pkg::OP_INSERT, {cht_pkg::KEY_W{1'b1}}, '1);
        queue_op(cht_pkg::OP_SEARCH, {cht_pkg::KEY_W{1'b1}}, 64'd0);
        queue_op(cht_pkg::OP_SEARCH, 31'd0, '1);
        queue_op(cht_pkg::OP_INSERT, 31'd8, 64'h0123_4567_89AB_CDEF);
        queue_op(cht_pkg::OP_INSERT, 31'd16, 64'hFEDC_BA98_7654_3210);
        queue_op(cht_pkg::OP_INSERT, 31'd24, 64'h8000_0000_0000_0001);
        queue_op(cht_pkg::OP_SEARCH, 31'd24, 64'd0);
        queue_op(cht_pkg::OP_SEARCH, 31'd16, 64'd0);
        queue_op(cht_pkg::OP_SEARCH, 31'd8, 64'd0);
        queue_op(cht_pkg::OP_SEARCH, 31'd0, 64'd0);
        queue_op(cht_pkg::OP_SEARCH, 31'd32, 64'd0);
        queue_op(cht_pkg::OP_INSERT, 31'd16, 64'h5555_AAAA_5555_AAAA);
        queue_op(cht_pkg::OP_INSERT, 31'd16, 64'hAAAA_5555_AAAA_5555);
        queue_op(cht_pkg::OP_SEARCH, 31'd16, 64'd0);
        queue_op(cht_pkg::OP_INSERT, 31'h4000_0000, 64'h7FFF_FFFF_FFFF_FFFF);
        queue_op(cht_pkg::OP_SEARCH, 31'h4000_0000, 64'd0);
        queue_op(cht_pkg::OP_INSERT, 31'd0, '1);
        queue_op(cht_pkg::OP_SEARCH, 31'd0, 64'd0);
        queue_op(cht_pkg::OP_SEARCH, 31'h7FFF_FFF7, '1);
        queue_op(cht_pkg::OP_INSERT, 31'd5, 64'd1);
        wait_for_drain();

        // Random phases; each one ends with the sender paused until the block is empty.
        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct = send_pct[phase];
            recv_stall_pct = recv_pct[phase];
            for (int i = 0; i < PHASE_ITEMS; i++) queue_random_op();
            // With the receiver held off and the sender flooding, the input must stall.
            if (phase == 2) hold_go = 1'b1;
            wait_for_drain();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Covered %0d operations: %0d inserted, %0d updated, %0d found,",
                 ops_accepted, status_count[cht_pkg::ST_INSERTED],
                 status_count[cht_pkg::ST_UPDATED], status_count[cht_pkg::ST_FOUND]);
        $display("%0d not found and %0d rejected with the pool full; %0d mismatches.",
                 status_count[cht_pkg::ST_NOT_FOUND], status_count[cht_pkg::ST_POOL_FULL],
                 errors);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
